// ===== rtl/bmds_pkg.sv =====
// Shared constants for the multiplexed BCD display scan driver.
package bmds_pkg;

  // Built maximum number of display digits.
  localparam int MAX_DIGITS_DEF = 8;

  // Field widths.
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 4;
  localparam int BCD_W    = 4;
  localparam int ENABLE_W = 8;
  localparam int SLOT_W   = 3;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = VALUE_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_VALUE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT   = 1'd1;

  // Reset value of the digit count register.
  localparam logic [COUNT_W-1:0] DIGIT_COUNT_RST = 4'd3;

  // Shift-and-add-3 correction for one BCD digit.
  function automatic logic [BCD_W-1:0] dabble_adj(input logic [BCD_W-1:0] d);
    logic [BCD_W-1:0] r;
    begin
      if (d >= 4'd5) begin
        r = d + 4'd3;
      end else begin
        r = d;
      end
      return r;
    end
  endfunction

endpackage

// ===== rtl/bmds_conv.sv =====
// Bit-serial binary to BCD converter (shift and add 3), one value bit per cycle.
module bmds_conv #(
  parameter int MAX_DIGITS = bmds_pkg::MAX_DIGITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      start,
  input  logic [bmds_pkg::VALUE_W-1:0]              value,
  output logic                                      busy,
  output logic [MAX_DIGITS-1:0][bmds_pkg::BCD_W-1:0] digits
);

  localparam int CNT_W = $clog2(bmds_pkg::VALUE_W + 1);

  logic [bmds_pkg::VALUE_W-1:0]               shifter;
  logic [MAX_DIGITS-1:0][bmds_pkg::BCD_W-1:0] bcd;
  logic [MAX_DIGITS-1:0][bmds_pkg::BCD_W-1:0] adj;
  logic [MAX_DIGITS*bmds_pkg::BCD_W-1:0]      adj_flat;
  logic [MAX_DIGITS*bmds_pkg::BCD_W-1:0]      bcd_next;
  logic [CNT_W-1:0]                           bits_left;

  // Correct every digit before the shift; the digits are independent.
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      adj[i] = bmds_pkg::dabble_adj(bcd[i]);
    end
  end

  assign adj_flat = adj;

  // Shift the next value bit into the least significant digit.
  // Carries out of the top digit are dropped, which keeps the value modulo
  // ten to the number of digits.
  assign bcd_next = {adj_flat[MAX_DIGITS*bmds_pkg::BCD_W-2:0], shifter[bmds_pkg::VALUE_W-1]};

  // Conversion sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      bits_left <= '0;
      bcd       <= '0;
    end else if (start) begin
      busy      <= 1'b1;
      bits_left <= CNT_W'(bmds_pkg::VALUE_W);
      bcd       <= '0;
    end else if (busy) begin
      bcd       <= bcd_next;
      bits_left <= bits_left - 1'b1;
      if (bits_left == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Value shift register, payload only.
  always_ff @(posedge clk) begin
    if (start) begin
      shifter <= value;
    end else if (busy) begin
      shifter <= {shifter[bmds_pkg::VALUE_W-2:0], 1'b0};
    end
  end

  assign digits = bcd;

endmodule

// ===== rtl/bcd_multiplexed_display_scan_top.sv =====
// Multiplexed BCD display scan driver: configuration, digit conversion and slot scan.
// A scan tick transfer is registered and shows its result in the next cycle; one tick
// per cycle when idle, with no write and a free output. A display value write starts
// a bit-serial conversion (one value bit per cycle) during which no tick is taken.
// Synchronous reset: digit count 3, slot 0, digit store cleared at once.
module bcd_multiplexed_display_scan_top #(
  parameter int MAX_DIGITS = bmds_pkg::MAX_DIGITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [bmds_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bmds_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                advance,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bmds_pkg::BCD_W-1:0]          bcd_lines,
  output logic [bmds_pkg::ENABLE_W-1:0]       digit_enable,
  output logic [bmds_pkg::SLOT_W-1:0]         slot_index
);

  localparam int DW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [bmds_pkg::COUNT_W-1:0] MAX_CNT = bmds_pkg::COUNT_W'(MAX_DIGITS);

  logic [bmds_pkg::COUNT_W-1:0]               digit_count;
  logic [bmds_pkg::COUNT_W-1:0]               n_used;
  logic [DW-1:0]                              slot;
  logic [DW-1:0]                              slot_next;
  logic [bmds_pkg::COUNT_W-1:0]               slot_inc;
  logic [bmds_pkg::COUNT_W-1:0]               sel_wide;
  logic [MAX_DIGITS-1:0][bmds_pkg::BCD_W-1:0] digits;
  logic [MAX_DIGITS-1:0]                      onehot;
  logic                                       conv_start;
  logic                                       conv_busy;
  logic                                       in_xfer;

  // Configuration writes.
  assign conv_start = cfg_write && (cfg_index == bmds_pkg::REG_DISPLAY_VALUE);

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= bmds_pkg::DIGIT_COUNT_RST;
    end else if (cfg_write && (cfg_index == bmds_pkg::REG_DIGIT_COUNT)) begin
      digit_count <= cfg_data[bmds_pkg::COUNT_W-1:0];
    end
  end

  // Digits in use: zero counts as one, large counts saturate.
  always_comb begin
    if (digit_count == '0) begin
      n_used = bmds_pkg::COUNT_W'(1);
    end else if (digit_count > MAX_CNT) begin
      n_used = MAX_CNT;
    end else begin
      n_used = digit_count;
    end
  end

  bmds_conv #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_conv (
    .clk    (clk),
    .rst    (rst),
    .start  (conv_start),
    .value  (cfg_data),
    .busy   (conv_busy),
    .digits (digits)
  );

  // Input transfer with the converter idle, no write and the output register free.
  assign in_ready = !conv_busy && !cfg_write && (!out_valid || out_ready);
  assign in_xfer  = in_valid && in_ready;

  // Slot update: optional advance with wrap, then fall back to slot 0
  // when the slot lies past the digits in use.
  always_comb begin
    slot_inc = bmds_pkg::COUNT_W'(slot) + 1'b1;
    if (advance) begin
      if (slot_inc >= n_used) begin
        slot_next = '0;
      end else begin
        slot_next = slot_inc[DW-1:0];
      end
    end else if (bmds_pkg::COUNT_W'(slot) >= n_used) begin
      slot_next = '0;
    end else begin
      slot_next = slot;
    end
  end

  // Slot 0 shows the most significant digit in use.
  assign sel_wide = n_used - 1'b1 - bmds_pkg::COUNT_W'(slot_next);
  assign onehot   = MAX_DIGITS'(1) << slot_next;

  // Slot and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_xfer) begin
        slot      <= slot_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      bcd_lines    <= digits[sel_wide[DW-1:0]];
      digit_enable <= bmds_pkg::ENABLE_W'(onehot);
      slot_index   <= bmds_pkg::SLOT_W'(slot_next);
    end
  end

endmodule
